>>> design/tsc_pkg.sv
package tsc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgW = 20;
  localparam int unsigned CfgIdxW = 3;

  // fixed dwell and report intervals, milliseconds
  localparam logic [TimeW-1:0] PATIENCE_MS = 32'd2000;
  localparam logic [TimeW-1:0] STEALING_MS = 32'd2000;
  localparam logic [TimeW-1:0] SKULKING_MS = 32'd2000;
  localparam logic [TimeW-1:0] FLOW_REPORT_MS = 32'd1000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BUZZ_OFF = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ENGAGING = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ENGAGED = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GULPING = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DEGAGING = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_EIGHTY_SIX = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_POUR_IDLE = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_POUR_WAIT = 3'd7;

  // configuration reset values
  localparam logic [CfgW-1:0] BUZZ_OFF_RST = 20'd3000;
  localparam logic [CfgW-1:0] ENGAGING_RST = 20'd2000;
  localparam logic [CfgW-1:0] ENGAGED_RST = 20'd30000;
  localparam logic [CfgW-1:0] GULPING_RST = 20'd3000;
  localparam logic [CfgW-1:0] DEGAGING_RST = 20'd10000;
  localparam logic [CfgW-1:0] EIGHTY_SIX_RST = 20'd3000;
  localparam logic [CfgW-1:0] POUR_IDLE_RST = 20'd60000;
  localparam logic [CfgW-1:0] POUR_WAIT_RST = 20'd30000;

  // reported state codes
  localparam logic [3:0] CODE_BORED = 4'd0;
  localparam logic [3:0] CODE_BUZZ_OFF = 4'd1;
  localparam logic [3:0] CODE_ENGAGING = 4'd2;
  localparam logic [3:0] CODE_ENGAGED = 4'd3;
  localparam logic [3:0] CODE_PATIENCE = 4'd4;
  localparam logic [3:0] CODE_POURING = 4'd5;
  localparam logic [3:0] CODE_GULPING = 4'd6;
  localparam logic [3:0] CODE_DEGAGING = 4'd7;
  localparam logic [3:0] CODE_EIGHTY_SIX = 4'd8;
  localparam logic [3:0] CODE_STEALING = 4'd9;
  localparam logic [3:0] CODE_STOLEN = 4'd10;
  localparam logic [3:0] CODE_SKULKING = 4'd11;

  typedef enum logic [11:0] {
    ST_BORED      = 12'b0000_0000_0001,
    ST_BUZZ_OFF   = 12'b0000_0000_0010,
    ST_ENGAGING   = 12'b0000_0000_0100,
    ST_ENGAGED    = 12'b0000_0000_1000,
    ST_PATIENCE   = 12'b0000_0001_0000,
    ST_POURING    = 12'b0000_0010_0000,
    ST_GULPING    = 12'b0000_0100_0000,
    ST_DEGAGING   = 12'b0000_1000_0000,
    ST_EIGHTY_SIX = 12'b0001_0000_0000,
    ST_STEALING   = 12'b0010_0000_0000,
    ST_STOLEN     = 12'b0100_0000_0000,
    ST_SKULKING   = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic [TimeW-1:0]  now_ms;
    logic              steal_pressed;
    logic              action_level;
    logic              key_valid;
    logic              key_authorized;
    logic [CountW-1:0] flow_count;
  } item_t;

  typedef struct packed {
    logic [3:0]        session_state;
    logic              valve_open;
    logic              fault;
    logic              report_valid;
    logic [CountW-1:0] report_pulses;
    logic [TimeW-1:0]  report_elapsed_ms;
  } result_t;

  typedef struct packed {
    logic [CfgW-1:0] buzz_off_time;
    logic [CfgW-1:0] engaging_time;
    logic [CfgW-1:0] engaged_time;
    logic [CfgW-1:0] gulping_time;
    logic [CfgW-1:0] degaging_time;
    logic [CfgW-1:0] eighty_six_time;
    logic [CfgW-1:0] pour_idle_time;
    logic [CfgW-1:0] pour_wait_time;
  } cfg_t;

  typedef struct packed {
    state_t            state;
    logic [TimeW-1:0]  state_start_ms;
    logic [CountW-1:0] session_start_count;
    logic [TimeW-1:0]  session_start_ms;
    logic [CountW-1:0] last_flow_count;
    logic [TimeW-1:0]  last_flow_ms;
    logic [TimeW-1:0]  last_report_uptime;
  } sess_t;

endpackage

>>> design/tsc_cfg.sv
module tsc_cfg import tsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buzz_off_time   <= BUZZ_OFF_RST;
      cfg.engaging_time   <= ENGAGING_RST;
      cfg.engaged_time    <= ENGAGED_RST;
      cfg.gulping_time    <= GULPING_RST;
      cfg.degaging_time   <= DEGAGING_RST;
      cfg.eighty_six_time <= EIGHTY_SIX_RST;
      cfg.pour_idle_time  <= POUR_IDLE_RST;
      cfg.pour_wait_time  <= POUR_WAIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BUZZ_OFF:   cfg.buzz_off_time   <= cfg_data;
        CFG_ENGAGING:   cfg.engaging_time   <= cfg_data;
        CFG_ENGAGED:    cfg.engaged_time    <= cfg_data;
        CFG_GULPING:    cfg.gulping_time    <= cfg_data;
        CFG_DEGAGING:   cfg.degaging_time   <= cfg_data;
        CFG_EIGHTY_SIX: cfg.eighty_six_time <= cfg_data;
        CFG_POUR_IDLE:  cfg.pour_idle_time  <= cfg_data;
        CFG_POUR_WAIT:  cfg.pour_wait_time  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> design/tsc_step.sv
module tsc_step import tsc_pkg::*; (
  input  item_t   item,
  input  sess_t   sess,
  input  cfg_t    cfg,
  output sess_t   sess_next,
  output result_t res
);

  function automatic sess_t go_to(sess_t r, state_t s, logic [TimeW-1:0] now,
                                  logic [CountW-1:0] flow);
    sess_t o;
    o = r;
    o.state = s;
    o.state_start_ms = now;
    if (s == ST_POURING || s == ST_STOLEN) begin
      o.session_start_count = flow;
      o.session_start_ms = now;
      o.last_flow_count = flow;
      o.last_flow_ms = now;
      o.last_report_uptime = '0;
    end
    return o;
  endfunction

  function automatic logic [3:0] encode(state_t s);
    logic [3:0] c;
    case (s)
      ST_BORED:      c = CODE_BORED;
      ST_BUZZ_OFF:   c = CODE_BUZZ_OFF;
      ST_ENGAGING:   c = CODE_ENGAGING;
      ST_ENGAGED:    c = CODE_ENGAGED;
      ST_PATIENCE:   c = CODE_PATIENCE;
      ST_POURING:    c = CODE_POURING;
      ST_GULPING:    c = CODE_GULPING;
      ST_DEGAGING:   c = CODE_DEGAGING;
      ST_EIGHTY_SIX: c = CODE_EIGHTY_SIX;
      ST_STEALING:   c = CODE_STEALING;
      ST_STOLEN:     c = CODE_STOLEN;
      ST_SKULKING:   c = CODE_SKULKING;
      default:       c = CODE_BORED;
    endcase
    return c;
  endfunction

  sess_t             r;
  logic              fault;
  logic              rep;
  logic [CountW-1:0] rep_pulses;
  logic [TimeW-1:0]  rep_elapsed;
  logic [TimeW-1:0]  up;
  logic [TimeW-1:0]  idle;
  logic              valve;
  logic [TimeW-1:0]  now;
  logic [CountW-1:0] flow;

  assign now = item.now_ms;
  assign flow = item.flow_count;

  always_comb begin
    r = sess;
    fault = 1'b0;
    rep = 1'b0;
    rep_pulses = '0;
    rep_elapsed = '0;
    idle = '0;

    // override button
    if (item.steal_pressed) begin
      case (r.state)
        ST_ENGAGING, ST_ENGAGED, ST_PATIENCE, ST_POURING, ST_GULPING, ST_DEGAGING: begin
          r = go_to(r, ST_EIGHTY_SIX, now, flow);
        end
        ST_EIGHTY_SIX, ST_BUZZ_OFF, ST_STEALING, ST_STOLEN, ST_SKULKING: ;
        default: r = go_to(r, ST_STEALING, now, flow);
      endcase
    end else if (r.state == ST_STOLEN || r.state == ST_STEALING) begin
      r = go_to(r, ST_SKULKING, now, flow);
    end

    // action toggle, compared against the valve drive of the state so far
    valve = (r.state == ST_POURING) || (r.state == ST_STOLEN);
    if (item.action_level != valve) begin
      case (r.state)
        ST_BORED: begin
          if (item.action_level) r = go_to(r, ST_BUZZ_OFF, now, flow);
          else fault = 1'b1;
        end
        ST_ENGAGED, ST_DEGAGING: begin
          if (item.action_level) r = go_to(r, ST_POURING, now, flow);
          else fault = 1'b1;
        end
        ST_POURING: begin
          if (item.action_level) fault = 1'b1;
          else r = go_to(r, ST_GULPING, now, flow);
        end
        default: ;
      endcase
    end

    // key presented
    if ((r.state == ST_BORED || r.state == ST_ENGAGED) && item.key_valid) begin
      r = go_to(r, item.key_authorized ? ST_ENGAGING : ST_BUZZ_OFF, now, flow);
    end

    // dwell timeouts and flow tracking
    up = now - r.state_start_ms;
    case (r.state)
      ST_BORED: ;
      ST_BUZZ_OFF: begin
        if (up >= {12'd0, cfg.buzz_off_time}) r = go_to(r, ST_BORED, now, flow);
      end
      ST_ENGAGING: begin
        if (up >= {12'd0, cfg.engaging_time}) r = go_to(r, ST_ENGAGED, now, flow);
      end
      ST_ENGAGED: begin
        if (up >= {12'd0, cfg.engaged_time}) r = go_to(r, ST_DEGAGING, now, flow);
      end
      ST_PATIENCE: begin
        if (up >= PATIENCE_MS) r = go_to(r, ST_POURING, now, flow);
      end
      ST_GULPING: begin
        if (up >= {12'd0, cfg.gulping_time}) r = go_to(r, ST_DEGAGING, now, flow);
      end
      ST_DEGAGING: begin
        if (up >= {12'd0, cfg.degaging_time}) r = go_to(r, ST_BORED, now, flow);
      end
      ST_EIGHTY_SIX: begin
        if (up >= {12'd0, cfg.eighty_six_time}) r = go_to(r, ST_BORED, now, flow);
      end
      ST_STEALING: begin
        if (up >= STEALING_MS) r = go_to(r, ST_STOLEN, now, flow);
      end
      ST_SKULKING: begin
        if (up >= SKULKING_MS) r = go_to(r, ST_BORED, now, flow);
      end
      ST_POURING, ST_STOLEN: begin
        idle = now - r.last_flow_ms;
        if (flow == r.last_flow_count) begin
          // gulping exit wins when both are due
          if (idle > {12'd0, cfg.pour_idle_time}) r = go_to(r, ST_GULPING, now, flow);
          else if (idle > {12'd0, cfg.pour_wait_time}) r = go_to(r, ST_DEGAGING, now, flow);
        end else begin
          r.last_flow_count = flow;
          r.last_flow_ms = now;
        end
        // report still goes out on an exit poll, timed by the state left
        if ((up - r.last_report_uptime) > FLOW_REPORT_MS) begin
          rep = 1'b1;
          rep_pulses = flow - r.session_start_count;
          rep_elapsed = now - r.session_start_ms;
          r.last_report_uptime = up;
        end
      end
      default: r = go_to(r, ST_BORED, now, flow);
    endcase

    sess_next = r;
    res.session_state = encode(r.state);
    res.valve_open = (r.state == ST_POURING) || (r.state == ST_STOLEN);
    res.fault = fault;
    res.report_valid = rep;
    res.report_pulses = rep_pulses;
    res.report_elapsed_ms = rep_elapsed;
  end

endmodule

>>> design/tap_session_controller_unit.sv
// channel   signals                            direction  payload
// item      item_valid / item_stall / item     in         item_t: one poll
// result    result_valid / result_stall / result  out     result_t: one per poll
// cfg       cfg_wr_en / cfg_index / cfg_data   in         20-bit timeout registers
//
// from poll transfer to result valid, the poll sits in the input register,
// then one pass of the rule logic loads the result register and updates the session state.
// one poll per cycle sustained while result_stall stays low.
// rst (synchronous) puts the machine in bored with all timestamps and counts at zero
// and loads the default timeouts.
// a held result stalls the input register, which then stalls the item channel.
module tap_session_controller_unit import tsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_q_valid;
  sess_t   sess;
  sess_t   sess_next;
  result_t res;
  logic    out_free;

  tsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tsc_step u_step (
    .item      (item_q),
    .sess      (sess),
    .cfg       (cfg),
    .sess_next (sess_next),
    .res       (res)
  );

  // result register can take a new transfer this cycle
  assign out_free = !result_valid || !result_stall;
  assign item_stall = item_q_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
      result_valid <= 1'b0;
      sess.state <= ST_BORED;
      sess.state_start_ms <= '0;
      sess.session_start_count <= '0;
      sess.session_start_ms <= '0;
      sess.last_flow_count <= '0;
      sess.last_flow_ms <= '0;
      sess.last_report_uptime <= '0;
    end else begin
      if (!item_stall) begin
        item_q_valid <= item_valid;
      end
      if (out_free) begin
        result_valid <= item_q_valid;
        if (item_q_valid) begin
          sess <= sess_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      item_q <= item;
    end
    if (out_free && item_q_valid) begin
      result <= res;
    end
  end

endmodule
